// ----- design/button_press_event_detector_defines.svh -----
// ----------------------------------------------------------------------------
// Button press event detector: assertion macros
// Shared concurrent assertion forms used by the detector RTL.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_EVENT_DETECTOR_DEFINES_SVH
`define BUTTON_PRESS_EVENT_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BPED_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPED_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bped_pkg.sv -----
// ----------------------------------------------------------------------------
// Button press event detector package
// Widths, register indexes, reset values and shared structs.
// ----------------------------------------------------------------------------
`default_nettype none

package bped_pkg;

  // Width of all stored timestamps and time differences.
  localparam int TIME_WIDTH = 32;
  localparam int NOW_WIDTH  = 32;
  localparam int CFG_WIDTH  = 16;
  localparam int CFG_IDX_W  = 2;

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [CFG_WIDTH-1:0]  cfg_val_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_DOUBLE   = 2'd1,
    REG_LONG     = 2'd2
  } reg_idx_t;

  localparam cfg_val_t DEBOUNCE_RST = 16'd20;
  localparam cfg_val_t DOUBLE_RST   = 16'd300;
  localparam cfg_val_t LONG_RST     = 16'd1000;

  // Current configuration as seen by the evaluation logic.
  typedef struct packed {
    cfg_val_t debounce_ms;
    cfg_val_t double_press_ms;
    cfg_val_t long_press_ms;
  } cfg_t;

  // Event flags produced for one poll.
  typedef struct packed {
    logic rel;
    logic sgl;
    logic dbl;
    logic lng;
  } evt_t;

endpackage

`default_nettype wire

// ----- design/bped_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the debounce, double-press and long-press times.
// ----------------------------------------------------------------------------
`default_nettype none

module bped_cfg_regs
  import bped_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_WIDTH-1:0] cfg_data,
  output logic                      cfg_ready,
  output cfg_t                      cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  // Address decode; unknown indexes leave the registers alone.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DEBOUNCE: cfg_nxt.debounce_ms     = cfg_data;
        REG_DOUBLE:   cfg_nxt.double_press_ms = cfg_data;
        REG_LONG:     cfg_nxt.long_press_ms   = cfg_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms     <= DEBOUNCE_RST;
      cfg_r.double_press_ms <= DOUBLE_RST;
      cfg_r.long_press_ms   <= LONG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- design/bped_eval.sv -----
// ----------------------------------------------------------------------------
// Poll evaluation
// Button state registers and the single-pass release, press and long checks.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_press_event_detector_defines.svh"

module bped_eval
  import bped_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  fire,
  input  wire logic  pressed,
  input  wire time_t now,
  input  wire cfg_t  cfg,
  output evt_t       evt
);

  time_t last_edge_r,     last_edge_nxt;
  time_t last_release_r,  last_release_nxt;
  logic  held_r,          held_nxt;
  logic  long_reported_r, long_reported_nxt;

  time_t since_edge;
  time_t since_edge_upd;
  logic  debounced;

  // Time since the last accepted edge, wrapping.
  assign since_edge = now - last_edge_r;
  assign debounced  = since_edge > TIME_WIDTH'(cfg.debounce_ms);

  // Release, press and long checks in order; only the long check sees an earlier update (a press in this poll).
  always_comb begin
    last_edge_nxt     = last_edge_r;
    last_release_nxt  = last_release_r;
    held_nxt          = held_r;
    long_reported_nxt = long_reported_r;
    evt               = '0;

    if (!pressed && held_r && debounced) begin
      last_edge_nxt     = now;
      last_release_nxt  = now;
      held_nxt          = 1'b0;
      long_reported_nxt = 1'b0;
      evt.rel           = 1'b1;
    end

    if (pressed && !held_r && debounced) begin
      last_edge_nxt = now;
      held_nxt      = 1'b1;
      evt.sgl       = 1'b1;
      evt.dbl       = (now - last_release_r) <= TIME_WIDTH'(cfg.double_press_ms);
    end

    since_edge_upd = evt.sgl ? '0 : since_edge;
    if (pressed && !long_reported_r &&
        since_edge_upd >= TIME_WIDTH'(cfg.long_press_ms)) begin
      long_reported_nxt = 1'b1;
      evt.lng           = 1'b1;
    end
  end

  // State moves only when a poll is evaluated.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r     <= '0;
      last_release_r  <= '0;
      held_r          <= 1'b0;
      long_reported_r <= 1'b0;
    end else if (fire) begin
      last_edge_r     <= last_edge_nxt;
      last_release_r  <= last_release_nxt;
      held_r          <= held_nxt;
      long_reported_r <= long_reported_nxt;
    end
  end

  // Consistency checks between the event flags and the stored state.
  `BPED_ASSERT_IMP(a_dbl_needs_sgl, fire && evt.dbl, evt.sgl, "double without press")
  `BPED_ASSERT_IMP(a_rel_sgl_excl, fire, !(evt.rel && evt.sgl), "release and press together")
  `BPED_ASSERT_NXT(a_sgl_sets_held, fire && evt.sgl, held_r && last_edge_r == $past(now),
                   "press did not update state")
  `BPED_ASSERT_NXT(a_rel_clears, fire && evt.rel, !held_r && !long_reported_r,
                   "release did not clear hold state")
  `BPED_ASSERT_NXT(a_lng_once, fire && evt.lng, long_reported_r, "long press not recorded")

endmodule

`default_nettype wire

// ----- design/button_press_event_detector.sv -----
// ----------------------------------------------------------------------------
// Button press event detector
// Debounces polled button samples and reports release, press, double press
// and long press events.
// ----------------------------------------------------------------------------
// One poll is taken per clock cycle unless in_stall is high; each poll yields
// exactly one result: the poll lands in an input register, its checks run in
// combinational logic against the stored button state, and the flags land in
// the result register. One poll per cycle is sustained while out_stall is low,
// as the evaluation reads and updates the state in one step.
// Configuration registers should be written only while no poll is in flight.
`default_nettype none

module button_press_event_detector
  import bped_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Poll input channel.
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_pressed,
  input  wire logic [NOW_WIDTH-1:0] in_now_ms,
  // Result channel.
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_release_event,
  output logic                      out_single_event,
  output logic                      out_double_event,
  output logic                      out_long_event,
  // Configuration write channel.
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_WIDTH-1:0] cfg_data
);

  cfg_t  cfg;
  evt_t  evt;
  logic  s1_vld_r;
  logic  s1_pressed_r;
  time_t s1_now_r;
  logic  out_vld_r;
  evt_t  out_evt_r;
  logic  out_free;
  logic  fire;
  logic  in_xfer;

  bped_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  // Handshake: the result register frees when empty or drained this cycle.
  assign out_free = !out_vld_r || !out_stall;
  assign fire     = s1_vld_r && out_free;
  assign in_stall = s1_vld_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pressed_r <= in_pressed;
      s1_now_r     <= TIME_WIDTH'(in_now_ms);
    end
  end

  bped_eval u_eval (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .pressed (s1_pressed_r),
    .now     (s1_now_r),
    .cfg     (cfg),
    .evt     (evt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_evt_r <= evt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_release_event = out_evt_r.rel;
  assign out_single_event  = out_evt_r.sgl;
  assign out_double_event  = out_evt_r.dbl;
  assign out_long_event    = out_evt_r.lng;

endmodule

`default_nettype wire
